// ===== hdl/pbcu_pkg.sv =====
// shared types and constants of the packet byte to chunk unpacker
`timescale 1ns / 1ps

package pbcu_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgW      = 4;
  localparam int unsigned HdrCntW   = 5;
  localparam int unsigned ResBitsW  = 16;
  localparam int unsigned ResCntW   = 5;
  localparam int unsigned ChunkCntW = 4;
  localparam int unsigned MaxChunks = 8;

  localparam logic [CfgW-1:0] ChunkBitsReset = 4'd2;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

// ===== hdl/pbcu_ctrl.sv =====
// controller of the packet byte to chunk unpacker: item sequencing and output valid
`timescale 1ns / 1ps

module pbcu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic           m_ready_i,
  output logic           m_valid_o,
  output pbcu_pkg::cmd_t cmd_o,
  input  pbcu_pkg::sts_t sts_i
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_comb begin
    s_ready_o   = (state_q == ST_IDLE);
    out_free    = !out_valid_q || m_ready_i;
    cmd_o.load  = s_valid_i && s_ready_o;
    cmd_o.step  = (state_q == ST_RUN) && out_free;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd_o.step && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// ===== hdl/pbcu_datapath.sv =====
// datapath of the packet byte to chunk unpacker: residual store, chunk extraction, output register
`timescale 1ns / 1ps

module pbcu_datapath #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbcu_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic [pbcu_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          new_packet_i,
  input  pbcu_pkg::cmd_t                cmd_i,
  output pbcu_pkg::sts_t                sts_o,
  output logic [pbcu_pkg::ByteW-1:0]    out_value_o,
  output logic                          out_new_packet_o,
  output logic                          out_last_o
);

  typedef enum logic [1:0] {
    OP_HEADER,
    OP_FLUSH,
    OP_CHUNK
  } op_e;

  localparam logic [pbcu_pkg::HdrCntW-1:0] HdrBytes = pbcu_pkg::HdrCntW'(HEADER_BYTES);
  localparam logic [pbcu_pkg::ChunkCntW-1:0] ChunkMax =
    pbcu_pkg::ChunkCntW'(pbcu_pkg::MaxChunks);

  logic [pbcu_pkg::CfgW-1:0]      cfg_q;
  op_e                            op_q, op_d;
  logic                           in_payload_q, in_payload_d;
  logic [pbcu_pkg::HdrCntW-1:0]   hdr_cnt_q, hdr_cnt_d;
  logic [pbcu_pkg::ResBitsW-1:0]  bits_q, bits_d;
  logic [pbcu_pkg::ResCntW-1:0]   cnt_q, cnt_d;
  logic [pbcu_pkg::ChunkCntW-1:0] k_q, k_d;
  logic [pbcu_pkg::ByteW-1:0]     byte_q, byte_d;
  logic                           flag_q, flag_d;
  logic [pbcu_pkg::ByteW-1:0]     out_value_q, out_value_d;
  logic                           out_flag_q, out_flag_d;
  logic                           out_last_q, out_last_d;

  logic [pbcu_pkg::CfgW-1:0]      cb;
  logic [pbcu_pkg::ResCntW-1:0]   cb_w;
  logic [pbcu_pkg::ByteW-1:0]     mask;
  logic [pbcu_pkg::ResCntW-1:0]   cnt_new;
  logic [pbcu_pkg::ChunkCntW-1:0] k_new;
  logic [pbcu_pkg::ResBitsW-1:0]  shifted;
  logic [pbcu_pkg::ByteW-1:0]     chunk_full;
  logic [pbcu_pkg::ByteW-1:0]     chunk_short;
  logic [2:0]                     pad_sh;
  logic [3:0]                     cnt_keep;
  logic [pbcu_pkg::HdrCntW-1:0]   hdr_inc;
  logic                           last;

  always_comb begin
    if (cfg_q == '0) begin
      cb = 4'd1;
    end else if (cfg_q > 4'd8) begin
      cb = 4'd8;
    end else begin
      cb = cfg_q;
    end
    cb_w        = {1'b0, cb};
    mask        = 8'hff >> (4'd8 - cb);
    cnt_new     = cnt_q - cb_w;
    k_new       = k_q + 4'd1;
    shifted     = bits_q >> cnt_new;
    chunk_full  = shifted[7:0] & mask;
    pad_sh      = 3'(cb - cnt_q[3:0]);
    chunk_short = (bits_q[7:0] << pad_sh) & mask;
    cnt_keep    = cnt_new[3:0];
    hdr_inc     = hdr_cnt_q + 5'd1;

    op_d         = op_q;
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    bits_d       = bits_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    byte_d       = byte_q;
    flag_d       = flag_q;
    out_value_d  = out_value_q;
    out_flag_d   = out_flag_q;
    out_last_d   = out_last_q;
    last         = 1'b1;

    case (op_q)
      OP_HEADER: begin
        last = 1'b1;
      end
      OP_FLUSH: begin
        last = !((cnt_q != '0) && (k_q < ChunkMax - 4'd1));
      end
      OP_CHUNK: begin
        last = !((cnt_new >= cb_w) && (k_new < ChunkMax));
      end
      default: begin
        last = 1'b1;
      end
    endcase

    if (cmd_i.load) begin
      byte_d = data_byte_i;
      flag_d = new_packet_i;
      k_d    = '0;
      if (!in_payload_q) begin
        op_d = OP_HEADER;
      end else if (new_packet_i) begin
        op_d = OP_FLUSH;
      end else begin
        op_d   = OP_CHUNK;
        bits_d = {bits_q[7:0], data_byte_i};
        cnt_d  = cnt_q + 5'd8;
      end
    end else if (cmd_i.step) begin
      out_last_d = last;
      case (op_q)
        OP_HEADER: begin
          out_value_d  = byte_q;
          out_flag_d   = flag_q;
          hdr_cnt_d    = hdr_inc;
          in_payload_d = (hdr_inc >= HdrBytes);
        end
        OP_FLUSH: begin
          if (!last) begin
            out_flag_d = 1'b0;
            k_d        = k_new;
            if (cnt_q < cb_w) begin
              out_value_d = chunk_short;
              cnt_d       = '0;
            end else begin
              out_value_d = chunk_full;
              cnt_d       = cnt_new;
            end
          end else begin
            out_value_d  = byte_q;
            out_flag_d   = flag_q;
            bits_d       = '0;
            cnt_d        = '0;
            hdr_cnt_d    = 5'd1;
            in_payload_d = (5'd1 >= HdrBytes);
          end
        end
        OP_CHUNK: begin
          out_value_d = chunk_full;
          out_flag_d  = 1'b0;
          k_d         = k_new;
          cnt_d       = cnt_new;
          if (last) begin
            cnt_d  = {1'b0, cnt_keep};
            bits_d = bits_q & ~(16'hffff << cnt_keep);
          end
        end
        default: begin
          out_value_d = byte_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= pbcu_pkg::ChunkBitsReset;
      op_q         <= OP_HEADER;
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      bits_q       <= '0;
      cnt_q        <= '0;
      k_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      op_q         <= op_d;
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      bits_q       <= bits_d;
      cnt_q        <= cnt_d;
      k_q          <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    flag_q      <= flag_d;
    out_value_q <= out_value_d;
    out_flag_q  <= out_flag_d;
    out_last_q  <= out_last_d;
  end

  assign sts_o.last       = last;
  assign out_value_o      = out_value_q;
  assign out_new_packet_o = out_flag_q;
  assign out_last_o       = out_last_q;

endmodule

// ===== hdl/packet_byte_to_chunk_unpacker.sv =====
// top level of the packet byte to chunk unpacker
`timescale 1ns / 1ps

// Takes one byte item at a time with a new-packet flag in tuser. The first
// HEADER_BYTES bytes of a packet leave unchanged with their flag; after that
// every payload byte is appended to a residual bit store and cut MSB first
// into chunks of chunk_bits bits (written through cfg_we_i, values 0 and
// above 8 act as 1 and 8), each right aligned in tdata with tuser low.
// A flagged byte during payload first flushes the leftover bits as chunks,
// the last one zero-padded if short, then starts the next header. tlast marks
// the final result of each input item, which gives N results (1 to 8): the
// byte is first loaded into the residual store, then one chunk per cycle
// leaves the single extraction unit, slowed only by output back-pressure.
// A new item is taken while the final result waits.
module packet_byte_to_chunk_unpacker #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // data_byte
  input  logic       s_axis_tuser_i,   // new_packet
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // out_value
  output logic       m_axis_tuser_o,   // out_new_packet
  output logic       m_axis_tlast_o
);

  pbcu_pkg::cmd_t cmd;
  pbcu_pkg::sts_t sts;

  pbcu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  pbcu_datapath #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .data_byte_i      (s_axis_tdata_i),
    .new_packet_i     (s_axis_tuser_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_value_o      (m_axis_tdata_o),
    .out_new_packet_o (m_axis_tuser_o),
    .out_last_o       (m_axis_tlast_o)
  );

endmodule

// ===== hdl/pbcu_checker.sv =====
// port checker of the packet byte to chunk unpacker and its bind
`timescale 1ns / 1ps

module pbcu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again right after an accept");

  // a header byte with the flag set is always a single result
  a_flag_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("flagged item is not last");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped under back-pressure");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output item changed under back-pressure");

endmodule

bind packet_byte_to_chunk_unpacker pbcu_checker u_pbcu_checker (.*);

// ===== dv/pbcu_chunk_checker.sv =====
// checker for the packet byte to chunk unpacker: predicts every result item and compares
`timescale 1ns / 1ps

module pbcu_chunk_checker #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pbcu_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [7:0]                s_tdata_i,
  input  logic                      s_tuser_i,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [7:0]                m_tdata_i,
  input  logic                      m_tuser_i,
  input  logic                      m_tlast_i,
  output int                        err_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [7:0] val;
    logic       newpkt;
    logic       tlast;
  } out_item_t;

  out_item_t unpacked_q[$];

  logic [pbcu_pkg::CfgW-1:0]     chunk_bits_q;
  logic                          in_payload_q;
  logic [pbcu_pkg::HdrCntW-1:0]  hdr_cnt_q;
  logic [pbcu_pkg::ResBitsW-1:0] res_bits_q;
  logic [3:0]                    res_cnt_q;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    err_count_o = err_count_o + 1;
  endtask

  function automatic int unsigned chunk_width(input logic [pbcu_pkg::CfgW-1:0] w);
    if (w == '0) return 1;
    if (w > 4'd8) return 8;
    return int'(w);
  endfunction

  task automatic pass_header(input logic [7:0] b, input logic f);
    unpacked_q.push_back('{val: b, newpkt: f, tlast: 1'b0});
    hdr_cnt_q = hdr_cnt_q + 1'b1;
    if (hdr_cnt_q >= HEADER_BYTES) in_payload_q = 1'b1;
  endtask

  task automatic unpack_byte(input logic [7:0] b, input logic f);
    int unsigned cb;
    int unsigned mask;
    int unsigned cnt;
    int unsigned bits;
    int unsigned c;
    int          k;
    out_item_t   tail;
    cb   = chunk_width(chunk_bits_q);
    mask = (1 << cb) - 1;
    cnt  = res_cnt_q;
    bits = res_bits_q;
    k    = 0;
    if (!in_payload_q) begin
      pass_header(b, f);
    end else if (f) begin
      while (cnt > 0 && k < pbcu_pkg::MaxChunks - 1) begin
        if (cnt >= cb) begin
          c   = (bits >> (cnt - cb)) & mask;
          cnt = cnt - cb;
        end else begin
          c   = (bits << (cb - cnt)) & mask;
          cnt = 0;
        end
        unpacked_q.push_back('{val: c[7:0], newpkt: 1'b0, tlast: 1'b0});
        k++;
      end
      in_payload_q = 1'b0;
      hdr_cnt_q    = '0;
      res_bits_q   = '0;
      res_cnt_q    = '0;
      pass_header(b, f);
    end else begin
      bits = ((bits << 8) | b) & 32'hffff;
      cnt  = cnt + 8;
      while (cnt >= cb && k < pbcu_pkg::MaxChunks) begin
        c   = (bits >> (cnt - cb)) & mask;
        cnt = cnt - cb;
        unpacked_q.push_back('{val: c[7:0], newpkt: 1'b0, tlast: 1'b0});
        k++;
      end
      cnt = cnt & 32'hf;
      if (cnt == 0) bits = 0;
      else bits = bits & ((1 << cnt) - 1);
      res_bits_q = bits[pbcu_pkg::ResBitsW-1:0];
      res_cnt_q  = cnt[3:0];
    end
    tail       = unpacked_q.pop_back();
    tail.tlast = 1'b1;
    unpacked_q.push_back(tail);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      chunk_bits_q = pbcu_pkg::ChunkBitsReset;
      in_payload_q = 1'b0;
      hdr_cnt_q    = '0;
      res_bits_q   = '0;
      res_cnt_q    = '0;
      unpacked_q.delete();
      err_count_o  = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (unpacked_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item %02h user %0b last %0b",
                                    m_tdata_i, m_tuser_i, m_tlast_i));
        end else begin
          want = unpacked_q.pop_front();
          if (m_tdata_i !== want.val)
            report_mismatch($sformatf("tdata got %02h want %02h", m_tdata_i, want.val));
          if (m_tuser_i !== want.newpkt)
            report_mismatch($sformatf("tuser got %0b want %0b", m_tuser_i, want.newpkt));
          if (m_tlast_i !== want.tlast)
            report_mismatch($sformatf("tlast got %0b want %0b", m_tlast_i, want.tlast));
        end
      end
      if (s_tvalid_i && s_tready_i) unpack_byte(s_tdata_i, s_tuser_i);
      if (cfg_we_i) chunk_bits_q = cfg_wdata_i;
      pending_o = unpacked_q.size();
    end
  end

endmodule

// ===== dv/tb_packet_byte_to_chunk_unpacker.sv =====
// testbench top for the packet byte to chunk unpacker: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_packet_byte_to_chunk_unpacker;

  localparam int unsigned HdrBytes     = 4;
  localparam int unsigned PhaseItems   = 22;
  localparam int unsigned NumPhases    = 9;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 12;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_we_i        = 1'b0;
  logic [pbcu_pkg::CfgW-1:0] cfg_wdata_i     = '0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [7:0]                s_axis_tdata_i  = '0;
  logic                      s_axis_tuser_i  = 1'b0;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  logic [7:0]                m_axis_tdata_o;
  logic                      m_axis_tuser_o;
  logic                      m_axis_tlast_o;

  int err_count;
  int pending;
  int tx_idle_pct = 35;
  int rx_idle_pct = 75;
  int hold_req    = 0;

  logic [pbcu_pkg::CfgW-1:0] phase_width [NumPhases] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4,
                                                         4'd5, 4'd9, 4'd6, 4'd3};

  always #1 clk_i = ~clk_i;

  packet_byte_to_chunk_unpacker #(
    .HEADER_BYTES(HdrBytes)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  pbcu_chunk_checker #(
    .HEADER_BYTES(HdrBytes)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_i (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_i (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_i  (m_axis_tdata_o),
    .m_tuser_i  (m_axis_tuser_o),
    .m_tlast_i  (m_axis_tlast_o),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  // receiver side, with an optional long hold-off
  always @(negedge clk_i) begin
    int hold_left;
    int hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen       = hold_req;
      hold_left       = HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic f);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= f;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_chunk_width(input logic [pbcu_pkg::CfgW-1:0] w);
    wait_drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int sent;
    int nbytes;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // chunk width 2 from reset, flag inside the header
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h5a, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'ha5, 1'b0);
    // new packet with an empty store
    send_item(8'h3c, 1'b1);
    send_item(8'h81, 1'b0);
    send_item(8'h7e, 1'b0);
    send_item(8'h01, 1'b0);
    set_chunk_width(4'd3);
    send_item(8'hff, 1'b0);
    // flush of a padded remainder
    send_item(8'h96, 1'b1);
    send_item(8'h42, 1'b0);
    send_item(8'h24, 1'b0);
    send_item(8'h18, 1'b0);
    set_chunk_width(4'd7);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b0);
    // narrower chunks mid-payload (widths 1 and 0, eight chunks per byte), then 15 acting as 8
    set_chunk_width(4'd1);
    send_item(8'hc3, 1'b0);
    set_chunk_width(4'd0);
    send_item(8'h55, 1'b0);
    set_chunk_width(4'd15);
    send_item(8'he7, 1'b0);
    send_item(8'h00, 1'b1);
    wait_drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_chunk_width(phase_width[ph]);
      case (ph / 3)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 75;
        end
        1: begin
          tx_idle_pct = 75;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 6) hold_req++;
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(99) < 80) begin
          send_item(8'($urandom), 1'b1);
          for (int i = 1; i < HdrBytes; i++) send_item(8'($urandom), 1'b0);
          nbytes = $urandom_range(6);
          for (int i = 0; i < nbytes; i++) send_item(8'($urandom), 1'b0);
          sent += HdrBytes + nbytes;
        end else begin
          send_item(8'($urandom), 1'($urandom));
          sent++;
        end
      end
    end

    wait_drain();
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
